[src/cds_pkg.sv]
// Package for the chunk download scoreboard: geometry constants, codes,
// table row layout and the control structs between the modules. No dependencies.
`timescale 1ns / 1ps

package cds_pkg;

  // Download geometry
  localparam int unsigned CHUNK_SHIFT    = 12;
  localparam int unsigned CHUNK_BYTES    = 1 << CHUNK_SHIFT;
  localparam int unsigned SECTION_CHUNKS = 256;
  localparam int unsigned CHUNK_IDX_W    = $clog2(SECTION_CHUNKS);
  localparam int unsigned SECTION_SHIFT  = CHUNK_SHIFT + CHUNK_IDX_W;
  localparam int unsigned SECTION_BYTES  = CHUNK_BYTES * SECTION_CHUNKS;
  localparam int unsigned MAX_TRIES      = 4;

  // Field and state widths
  localparam int unsigned OFF_W     = 32;
  localparam int unsigned FLUSH_W   = SECTION_SHIFT + 1;
  localparam int unsigned TOTAL_W   = CHUNK_IDX_W + 1;
  localparam int unsigned SEC_IDX_W = 12;
  localparam int unsigned SEC_CNT_W = OFF_W - SECTION_SHIFT + 1;
  localparam int unsigned RETRY_W   = 3;
  localparam int unsigned STATUS_W  = 3;

  // Table layout: one memory row holds a group of chunk entries
  localparam int unsigned COL_W       = 4;
  localparam int unsigned ROW_ENTRIES = 1 << COL_W;
  localparam int unsigned ROWS        = SECTION_CHUNKS / ROW_ENTRIES;
  localparam int unsigned ROW_AW      = CHUNK_IDX_W - COL_W;

  // Request codes
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_NEXT   = 2'd1;
  localparam logic [1:0] REQ_REPORT = 2'd2;

  // Chunk state codes
  localparam logic [1:0] CST_MISSING = 2'd0;
  localparam logic [1:0] CST_FLIGHT  = 2'd1;
  localparam logic [1:0] CST_GOT     = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_MISSING  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_COMPLETE    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_STARTED = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_CANCELLED   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_RMW,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [RETRY_W-1:0] retry;
    logic [1:0]         cst;
  } entry_t;

  typedef entry_t [ROW_ENTRIES-1:0] row_t;

  typedef struct packed {
    logic              clr;
    logic              rd_en;
    logic [ROW_AW-1:0] rd_addr;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_addr;
    row_t              wr_data;
  } tbl_req_t;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    next_offset;
    logic [FLUSH_W-1:0]  flush_length;
    logic                section_done;
    logic                download_done;
  } res_t;

endpackage

[src/cds_table.sv]
// Chunk table memory: one row of entries per address, registered read.
// Per-row valid bits give the cleared value without a sweep. Uses cds_pkg.
`timescale 1ns / 1ps

module cds_table (
  input  logic              clk,
  input  logic              rst_n,
  input  cds_pkg::tbl_req_t req,
  output cds_pkg::row_t     rd_row
);

  cds_pkg::row_t                   mem [cds_pkg::ROWS];
  logic [cds_pkg::ROWS-1:0]        vld_r;
  logic [cds_pkg::ROWS-1:0]        vld_nxt;
  cds_pkg::row_t                   rd_data_r;
  logic                            rd_vld_r;

  // Write the addressed row
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  // Row valid bits: clear drops them all, a write marks its row
  always_comb begin
    vld_nxt = vld_r;
    if (req.clr) begin
      vld_nxt = '0;
    end else if (req.wr_en) begin
      vld_nxt[req.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  // A row never written since the last clear reads as all missing, no retries
  assign rd_row = rd_vld_r ? rd_data_r : '0;

endmodule

[src/cds_ctrl.sv]
// Scoreboard sequencer: decodes requests, scans the table for the first
// missing chunk, updates reported chunks and steps sections. Uses cds_pkg.
`timescale 1ns / 1ps

module cds_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [cds_pkg::OFF_W-1:0]   in_chunk_offset,
  input  logic                        in_chunk_found,
  input  logic [cds_pkg::OFF_W-1:0]   file_size,
  input  cds_pkg::row_t               rd_row,
  output cds_pkg::tbl_req_t           tbl_req,
  output cds_pkg::res_t               res,
  input  logic                        res_ready
);

  cds_pkg::state_t state_r, state_nxt;

  logic                                active_r, active_nxt;
  logic                                finished_r, finished_nxt;
  logic [cds_pkg::OFF_W-1:0]           held_r, held_nxt;
  logic [cds_pkg::SEC_IDX_W-1:0]       sec_idx_r, sec_idx_nxt;
  logic [cds_pkg::TOTAL_W-1:0]         total_r, total_nxt;
  logic [cds_pkg::TOTAL_W-1:0]         done_r, done_nxt;
  logic [cds_pkg::FLUSH_W-1:0]         sec_bytes_r, sec_bytes_nxt;
  logic                                last_r, last_nxt;
  logic [cds_pkg::ROW_AW-1:0]          row_r, row_nxt;
  logic [cds_pkg::COL_W-1:0]           col_r, col_nxt;
  logic                                found_r, found_nxt;

  logic [cds_pkg::STATUS_W-1:0]        res_status_r, res_status_nxt;
  logic [cds_pkg::OFF_W-1:0]           res_next_r, res_next_nxt;
  logic [cds_pkg::FLUSH_W-1:0]         res_flush_r, res_flush_nxt;
  logic                                res_sdone_r, res_sdone_nxt;
  logic                                res_ddone_r, res_ddone_nxt;

  logic                                acc;
  logic                                running;
  logic [cds_pkg::CHUNK_IDX_W-1:0]     in_idx;
  logic                                in_idx_ok;
  logic                                go_load;
  logic                                go_scan;
  logic                                go_rmw;

  // Section geometry
  logic [cds_pkg::SEC_CNT_W-1:0]       cnt_raw;
  logic [cds_pkg::SEC_CNT_W-1:0]       sec_cnt;
  logic                                ld_last;
  logic [cds_pkg::OFF_W-1:0]           ld_base;
  logic [cds_pkg::OFF_W-1:0]           ld_rest;
  logic [cds_pkg::FLUSH_W-1:0]         ld_bytes;
  logic [cds_pkg::TOTAL_W-1:0]         ld_total;

  // Row scan
  logic [cds_pkg::ROW_ENTRIES-1:0]     cand;
  logic                                scan_hit;
  logic [cds_pkg::COL_W-1:0]           scan_pick;
  logic [cds_pkg::TOTAL_W-1:0]         scan_nstart;
  logic                                scan_end;
  logic [63:0]                         scan_off_w;
  cds_pkg::row_t                       scan_row;

  // Read-modify-write of a reported entry
  cds_pkg::entry_t                     rmw_e;
  logic [cds_pkg::RETRY_W:0]           retry_inc;
  logic                                rmw_live;
  logic                                rmw_cancel;
  logic [cds_pkg::TOTAL_W-1:0]         done_inc;
  logic                                rmw_complete;
  logic                                rmw_advance;
  cds_pkg::row_t                       rmw_row;

  assign acc     = in_valid && !in_stall;
  assign running = active_r && !finished_r;
  assign in_idx  = in_chunk_offset[cds_pkg::SECTION_SHIFT-1:cds_pkg::CHUNK_SHIFT];
  assign in_idx_ok = {1'b0, in_idx} < total_r;

  // Request decode on acceptance
  always_comb begin
    go_load = 1'b0;
    go_scan = 1'b0;
    go_rmw  = 1'b0;
    if (acc) begin
      unique case (in_req_type)
        cds_pkg::REQ_START:  go_load = !active_r;
        cds_pkg::REQ_NEXT:   go_scan = running;
        cds_pkg::REQ_REPORT: go_rmw  = running && in_idx_ok;
        default: ;
      endcase
    end
  end

  // Section count, last-section flag, byte count and chunk total
  always_comb begin
    cnt_raw = cds_pkg::SEC_CNT_W'(held_r >> cds_pkg::SECTION_SHIFT)
            + cds_pkg::SEC_CNT_W'(|held_r[cds_pkg::SECTION_SHIFT-1:0]);
    sec_cnt = (cnt_raw == '0) ? cds_pkg::SEC_CNT_W'(1) : cnt_raw;
    ld_last = (cds_pkg::SEC_CNT_W'(sec_idx_r) + cds_pkg::SEC_CNT_W'(1)) >= sec_cnt;
    ld_base = cds_pkg::OFF_W'(sec_idx_r) << cds_pkg::SECTION_SHIFT;
    ld_rest = (held_r > ld_base) ? (held_r - ld_base) : '0;
    if (!ld_last || (ld_rest > cds_pkg::OFF_W'(cds_pkg::SECTION_BYTES))) begin
      ld_bytes = cds_pkg::FLUSH_W'(cds_pkg::SECTION_BYTES);
    end else begin
      ld_bytes = ld_rest[cds_pkg::FLUSH_W-1:0];
    end
    ld_total = ld_bytes[cds_pkg::FLUSH_W-1:cds_pkg::CHUNK_SHIFT]
             + cds_pkg::TOTAL_W'(|ld_bytes[cds_pkg::CHUNK_SHIFT-1:0]);
  end

  // Find the first missing entry of the row within the section
  always_comb begin
    for (int j = 0; j < cds_pkg::ROW_ENTRIES; j++) begin
      cand[j] = (rd_row[j].cst == cds_pkg::CST_MISSING)
             && (cds_pkg::TOTAL_W'({row_r, cds_pkg::COL_W'(j)}) < total_r);
    end
    scan_hit  = |cand;
    scan_pick = '0;
    for (int j = cds_pkg::ROW_ENTRIES - 1; j >= 0; j--) begin
      if (cand[j]) begin
        scan_pick = cds_pkg::COL_W'(j);
      end
    end
    scan_nstart = cds_pkg::TOTAL_W'((32'(row_r) + 32'd1) << cds_pkg::COL_W);
    scan_end    = scan_nstart >= total_r;
    scan_off_w  = (64'(sec_idx_r) << cds_pkg::SECTION_SHIFT)
                | (64'({row_r, scan_pick}) << cds_pkg::CHUNK_SHIFT);
    scan_row            = rd_row;
    scan_row[scan_pick].cst = cds_pkg::CST_FLIGHT;
  end

  // Update the reported entry
  always_comb begin
    rmw_e        = rd_row[col_r];
    retry_inc    = {1'b0, rmw_e.retry} + 1'b1;
    rmw_live     = rmw_e.cst != cds_pkg::CST_GOT;
    rmw_cancel   = retry_inc >= (cds_pkg::RETRY_W + 1)'(cds_pkg::MAX_TRIES);
    done_inc     = done_r + 1'b1;
    rmw_complete = done_inc >= total_r;
    rmw_advance  = (state_r == cds_pkg::ST_RMW) && rmw_live && found_r
                && rmw_complete && !last_r;
    rmw_row      = rd_row;
    if (found_r) begin
      rmw_row[col_r].cst = cds_pkg::CST_GOT;
    end else begin
      rmw_row[col_r].retry = retry_inc[cds_pkg::RETRY_W-1:0];
      if (!rmw_cancel) begin
        rmw_row[col_r].cst = cds_pkg::CST_MISSING;
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cds_pkg::ST_IDLE: begin
        if (acc) begin
          priority if (go_load) begin
            state_nxt = cds_pkg::ST_LOAD;
          end else if (go_scan) begin
            state_nxt = cds_pkg::ST_SCAN;
          end else if (go_rmw) begin
            state_nxt = cds_pkg::ST_RMW;
          end else begin
            state_nxt = cds_pkg::ST_RESULT;
          end
        end
      end
      cds_pkg::ST_LOAD: state_nxt = cds_pkg::ST_RESULT;
      cds_pkg::ST_SCAN: begin
        if (scan_hit || scan_end) begin
          state_nxt = cds_pkg::ST_RESULT;
        end
      end
      cds_pkg::ST_RMW: begin
        state_nxt = rmw_advance ? cds_pkg::ST_LOAD : cds_pkg::ST_RESULT;
      end
      cds_pkg::ST_RESULT: begin
        if (res_ready) begin
          state_nxt = cds_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cds_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake, table requests, result beat
  always_comb begin
    in_stall = state_r != cds_pkg::ST_IDLE;
    tbl_req  = '0;
    unique case (state_r)
      cds_pkg::ST_IDLE: begin
        tbl_req.rd_en   = go_scan || go_rmw;
        tbl_req.rd_addr = go_rmw ? in_idx[cds_pkg::CHUNK_IDX_W-1:cds_pkg::COL_W] : '0;
      end
      cds_pkg::ST_LOAD: tbl_req.clr = 1'b1;
      cds_pkg::ST_SCAN: begin
        tbl_req.rd_en   = !scan_hit && !scan_end;
        tbl_req.rd_addr = row_r + 1'b1;
        tbl_req.wr_en   = scan_hit;
        tbl_req.wr_addr = row_r;
        tbl_req.wr_data = scan_row;
      end
      cds_pkg::ST_RMW: begin
        tbl_req.wr_en   = rmw_live;
        tbl_req.wr_addr = row_r;
        tbl_req.wr_data = rmw_row;
      end
      default: ;
    endcase
    res.valid         = state_r == cds_pkg::ST_RESULT;
    res.status        = res_status_r;
    res.next_offset   = res_next_r;
    res.flush_length  = res_flush_r;
    res.section_done  = res_sdone_r;
    res.download_done = res_ddone_r;
  end

  // Scoreboard registers and result fields
  always_comb begin
    active_nxt     = active_r;
    finished_nxt   = finished_r;
    held_nxt       = held_r;
    sec_idx_nxt    = sec_idx_r;
    total_nxt      = total_r;
    done_nxt       = done_r;
    sec_bytes_nxt  = sec_bytes_r;
    last_nxt       = last_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    found_nxt      = found_r;
    res_status_nxt = res_status_r;
    res_next_nxt   = res_next_r;
    res_flush_nxt  = res_flush_r;
    res_sdone_nxt  = res_sdone_r;
    res_ddone_nxt  = res_ddone_r;
    unique case (state_r)
      cds_pkg::ST_IDLE: begin
        if (acc) begin
          res_status_nxt = cds_pkg::STAT_OK;
          res_next_nxt   = '0;
          res_flush_nxt  = '0;
          res_sdone_nxt  = 1'b0;
          res_ddone_nxt  = 1'b0;
          row_nxt        = go_rmw ? in_idx[cds_pkg::CHUNK_IDX_W-1:cds_pkg::COL_W] : '0;
          col_nxt        = in_idx[cds_pkg::COL_W-1:0];
          found_nxt      = in_chunk_found;
          if (go_load) begin
            held_nxt     = file_size;
            sec_idx_nxt  = '0;
            finished_nxt = file_size == '0;
            active_nxt   = file_size != '0;
          end
          if ((in_req_type == cds_pkg::REQ_NEXT) || (in_req_type == cds_pkg::REQ_REPORT)) begin
            if (finished_r) begin
              res_status_nxt = cds_pkg::STAT_COMPLETE;
            end else if (!active_r) begin
              res_status_nxt = cds_pkg::STAT_NOT_STARTED;
            end
          end
        end
      end
      cds_pkg::ST_LOAD: begin
        sec_bytes_nxt = ld_bytes;
        last_nxt      = ld_last;
        total_nxt     = ld_total;
        done_nxt      = '0;
      end
      cds_pkg::ST_SCAN: begin
        if (scan_hit) begin
          res_next_nxt = scan_off_w[cds_pkg::OFF_W-1:0];
        end else if (scan_end) begin
          res_status_nxt = cds_pkg::STAT_NO_MISSING;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end
      cds_pkg::ST_RMW: begin
        if (rmw_live) begin
          if (!found_r) begin
            if (rmw_cancel) begin
              active_nxt     = 1'b0;
              res_status_nxt = cds_pkg::STAT_CANCELLED;
            end
          end else begin
            done_nxt = done_inc;
            if (rmw_complete) begin
              res_flush_nxt = sec_bytes_r;
              res_sdone_nxt = 1'b1;
              if (last_r) begin
                active_nxt    = 1'b0;
                finished_nxt  = 1'b1;
                res_ddone_nxt = 1'b1;
              end else begin
                sec_idx_nxt = sec_idx_r + 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cds_pkg::ST_IDLE;
      active_r   <= 1'b0;
      finished_r <= 1'b0;
      held_r     <= '0;
      sec_idx_r  <= '0;
      total_r    <= '0;
      done_r     <= '0;
      last_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      active_r   <= active_nxt;
      finished_r <= finished_nxt;
      held_r     <= held_nxt;
      sec_idx_r  <= sec_idx_nxt;
      total_r    <= total_nxt;
      done_r     <= done_nxt;
      last_r     <= last_nxt;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    sec_bytes_r  <= sec_bytes_nxt;
    row_r        <= row_nxt;
    col_r        <= col_nxt;
    found_r      <= found_nxt;
    res_status_r <= res_status_nxt;
    res_next_r   <= res_next_nxt;
    res_flush_r  <= res_flush_nxt;
    res_sdone_r  <= res_sdone_nxt;
    res_ddone_r  <= res_ddone_nxt;
  end

endmodule

[src/chunk_download_scoreboard.sv]
// Top level of the chunk download scoreboard: file size register, output
// register, sequencer and chunk table. Uses cds_pkg, cds_table, cds_ctrl.
`timescale 1ns / 1ps

//  channel | ports                                  | direction
//  --------+----------------------------------------+----------------------
//  in      | in_valid in_stall in_req_type          | request beat in
//          | in_chunk_offset in_chunk_found         |
//  out     | out_valid out_stall out_status         | one result beat out
//          | out_next_offset out_flush_length       | per request
//          | out_section_done out_download_done     |
//  cfg     | cfg_we cfg_wdata                       | file size write
//
// One request at a time, accepted only while the sequencer is idle. A start
// clears the table in its load step; a report updates its row, and loads and
// clears the next section when it moves on; a next-chunk request scans one table
// row of 16 entries per scan cycle. Reset clears the table by row valid bits.
// A waiting result sits in the output register while the next beat is
// accepted; the sequencer holds its result only while that register is full.

module chunk_download_scoreboard (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_req_type,
  input  logic [cds_pkg::OFF_W-1:0]     in_chunk_offset,
  input  logic                          in_chunk_found,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cds_pkg::STATUS_W-1:0]  out_status,
  output logic [cds_pkg::OFF_W-1:0]     out_next_offset,
  output logic [cds_pkg::FLUSH_W-1:0]   out_flush_length,
  output logic                          out_section_done,
  output logic                          out_download_done,
  input  logic                          cfg_we,
  input  logic [cds_pkg::OFF_W-1:0]     cfg_wdata
);

  logic [cds_pkg::OFF_W-1:0]  file_size_r;
  logic                       out_valid_r, out_valid_nxt;
  cds_pkg::res_t              out_r;
  cds_pkg::res_t              res;
  cds_pkg::tbl_req_t          tbl_req;
  cds_pkg::row_t              rd_row;
  logic                       res_ready;

  // File size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_size_r <= '0;
    end else if (cfg_we) begin
      file_size_r <= cfg_wdata;
    end
  end

  cds_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_chunk_offset (in_chunk_offset),
    .in_chunk_found  (in_chunk_found),
    .file_size       (file_size_r),
    .rd_row          (rd_row),
    .tbl_req         (tbl_req),
    .res             (res),
    .res_ready       (res_ready)
  );

  cds_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (tbl_req),
    .rd_row (rd_row)
  );

  // Output register: take a result when empty or being drained
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (res.valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_next_offset   = out_r.next_offset;
  assign out_flush_length  = out_r.flush_length;
  assign out_section_done  = out_r.section_done;
  assign out_download_done = out_r.download_done;

endmodule

[bench/tb_top.sv]
// Self-checking bench for chunk_download_scoreboard: a planned request stream,
// a clocked driver and monitor, and an in-bench scoreboard predictor.
// Depends on cds_pkg and the chunk_download_scoreboard RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned     OFF_W          = cds_pkg::OFF_W;
  localparam int unsigned     STATUS_W       = cds_pkg::STATUS_W;
  localparam int unsigned     FLUSH_W        = cds_pkg::FLUSH_W;
  localparam int unsigned     RETRY_W        = cds_pkg::RETRY_W;
  localparam int unsigned     SECTION_CHUNKS = cds_pkg::SECTION_CHUNKS;
  localparam int unsigned     CHUNK_BYTES    = cds_pkg::CHUNK_BYTES;
  localparam int unsigned     SECTION_SHIFT  = cds_pkg::SECTION_SHIFT;
  localparam int unsigned     CHUNK_SHIFT    = cds_pkg::CHUNK_SHIFT;
  localparam int unsigned     CHUNK_IDX_W    = cds_pkg::CHUNK_IDX_W;
  localparam int unsigned     MAX_TRIES      = cds_pkg::MAX_TRIES;
  localparam logic [1:0]      REQ_UNUSED     = 2'd3;
  localparam longint unsigned SEC_B          = cds_pkg::SECTION_BYTES;
  localparam longint unsigned CHK_B          = cds_pkg::CHUNK_BYTES;
  localparam int unsigned     BEAT_TARGET    = 1400;
  localparam int unsigned     CALM_TAIL      = 120;
  localparam int unsigned     WATCHDOG_LIMIT = 2000;
  localparam int unsigned     DRAIN_CYCLES   = 40;

  typedef enum logic [1:0] {
    STEP_BEAT,
    STEP_SIZE_WRITE,
    STEP_SETTLE
  } step_kind_t;

  typedef struct {
    step_kind_t       kind;
    logic [1:0]       req;
    logic [OFF_W-1:0] offset;
    logic             found;
    logic [OFF_W-1:0] size;
  } plan_step_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    next_offset;
    logic [FLUSH_W-1:0]  flush_length;
    logic                section_done;
    logic                download_done;
  } reply_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_req_type = cds_pkg::REQ_START;
  logic [OFF_W-1:0]    in_chunk_offset = '0;
  logic                in_chunk_found = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [OFF_W-1:0]    out_next_offset;
  logic [FLUSH_W-1:0]  out_flush_length;
  logic                out_section_done;
  logic                out_download_done;
  logic                cfg_we = 1'b0;
  logic [OFF_W-1:0]    cfg_wdata = '0;

  plan_step_t  backlog[$];
  reply_t      predicted_replies[$];
  int unsigned beats_planned = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_no = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  logic        send_quiet = 1'b0;
  logic        recv_quiet = 1'b0;
  logic        tail_calm = 1'b0;
  logic        stim_done = 1'b0;

  // Predictor state: chunk table, section position and the size register
  logic [1:0]         tbl_state [SECTION_CHUNKS];
  logic [RETRY_W-1:0] tbl_retry [SECTION_CHUNKS];
  int unsigned        got_count = 0;
  int unsigned        sec_idx = 0;
  int unsigned        sec_total = 0;
  logic               dl_active = 1'b0;
  logic               dl_finished = 1'b0;
  logic [OFF_W-1:0]   size_reg = '0;
  logic [OFF_W-1:0]   size_held = '0;

  chunk_download_scoreboard dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_chunk_offset   (in_chunk_offset),
    .in_chunk_found    (in_chunk_found),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_next_offset   (out_next_offset),
    .out_flush_length  (out_flush_length),
    .out_section_done  (out_section_done),
    .out_download_done (out_download_done),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Section geometry of the latched file size
  function automatic longint unsigned section_total_count();
    longint unsigned n;
    n = (64'(size_held) + SEC_B - 1) / SEC_B;
    return (n == 0) ? 1 : n;
  endfunction

  function automatic logic in_last_section();
    return (64'(sec_idx) + 1) >= section_total_count();
  endfunction

  function automatic longint unsigned bytes_in_section();
    longint unsigned base, rest;
    if (!in_last_section()) return SEC_B;
    base = 64'(sec_idx) * SEC_B;
    rest = (64'(size_held) > base) ? 64'(size_held) - base : 0;
    return (rest > SEC_B) ? SEC_B : rest;
  endfunction

  // Size the current section and clear its table
  function automatic void open_section();
    sec_total = int'((bytes_in_section() + CHK_B - 1) / CHK_B);
    for (int k = 0; k < SECTION_CHUNKS; k++) begin
      tbl_state[k] = cds_pkg::CST_MISSING;
      tbl_retry[k] = '0;
    end
    got_count = 0;
  endfunction

  // Advance the scoreboard by one request and return the result it gives
  function automatic reply_t score_request(input logic [1:0] req,
                                           input logic [OFF_W-1:0] off,
                                           input logic found);
    reply_t      r;
    int unsigned k;
    int unsigned idx;
    r = '0;
    case (req)
      cds_pkg::REQ_START: begin
        if (!dl_active) begin
          size_held   = size_reg;
          sec_idx     = 0;
          dl_finished = 1'b0;
          open_section();
          if (size_held == 0) begin
            dl_finished = 1'b1;
            dl_active   = 1'b0;
          end else begin
            dl_active = 1'b1;
          end
        end
      end
      cds_pkg::REQ_NEXT, cds_pkg::REQ_REPORT: begin
        if (dl_finished) begin
          r.status = cds_pkg::STAT_COMPLETE;
        end else if (!dl_active) begin
          r.status = cds_pkg::STAT_NOT_STARTED;
        end else if (req == cds_pkg::REQ_NEXT) begin
          k = 0;
          while (k < sec_total && k < SECTION_CHUNKS &&
                 tbl_state[k] != cds_pkg::CST_MISSING) k++;
          if (k >= sec_total || k >= SECTION_CHUNKS) begin
            r.status = cds_pkg::STAT_NO_MISSING;
          end else begin
            tbl_state[k]  = cds_pkg::CST_FLIGHT;
            r.next_offset = OFF_W'(64'(k) * CHK_B + 64'(sec_idx) * SEC_B);
          end
        end else begin
          idx = int'(off[SECTION_SHIFT-1:CHUNK_SHIFT]);
          if (idx < sec_total && tbl_state[idx] != cds_pkg::CST_GOT) begin
            if (!found) begin
              tbl_retry[idx] = tbl_retry[idx] + 1'b1;
              if (tbl_retry[idx] >= MAX_TRIES) begin
                dl_active = 1'b0;
                r.status  = cds_pkg::STAT_CANCELLED;
              end else begin
                tbl_state[idx] = cds_pkg::CST_MISSING;
              end
            end else begin
              tbl_state[idx] = cds_pkg::CST_GOT;
              got_count++;
              if (got_count >= sec_total) begin
                r.flush_length = FLUSH_W'(bytes_in_section());
                r.section_done = 1'b1;
                if (in_last_section()) begin
                  dl_active       = 1'b0;
                  dl_finished     = 1'b1;
                  r.download_done = 1'b1;
                end else begin
                  sec_idx = (sec_idx + 1) & 32'hFFF;
                  open_section();
                end
              end
            end
          end
        end
      end
      default: ;  // unknown request: no effect
    endcase
    return r;
  endfunction

  // Request planning
  task automatic plan_beat(input logic [1:0] req, input logic [OFF_W-1:0] off,
                           input logic found);
    plan_step_t s;
    s.kind   = STEP_BEAT;
    s.req    = req;
    s.offset = off;
    s.found  = found;
    s.size   = '0;
    backlog.push_back(s);
    beats_planned++;
  endtask

  task automatic plan_size(input logic [OFF_W-1:0] sz);
    plan_step_t s;
    s.kind   = STEP_SIZE_WRITE;
    s.req    = cds_pkg::REQ_START;
    s.offset = '0;
    s.found  = 1'b0;
    s.size   = sz;
    backlog.push_back(s);
  endtask

  task automatic plan_settle();
    plan_step_t s;
    s.kind   = STEP_SETTLE;
    s.req    = cds_pkg::REQ_START;
    s.offset = '0;
    s.found  = 1'b0;
    s.size   = '0;
    backlog.push_back(s);
  endtask

  task automatic plan_start();
    plan_beat(cds_pkg::REQ_START, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic plan_ask();
    plan_beat(cds_pkg::REQ_NEXT, $urandom, 1'($urandom_range(0, 1)));
  endtask

  // Report a chunk by position; the section bits and the byte bits are random
  task automatic plan_report(input int unsigned idx, input logic found);
    logic [OFF_W-1:0] a;
    a = $urandom;
    a[SECTION_SHIFT-1:CHUNK_SHIFT] = CHUNK_IDX_W'(idx);
    plan_beat(cds_pkg::REQ_REPORT, a, found);
  endtask

  // Well-formed small download: ask then report, with misses and harmless noise
  task automatic plan_small_download(input int unsigned miss_pct);
    int unsigned n, cur, miss;
    logic        dropped;
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    plan_size((n - 1) * CHUNK_BYTES + $urandom_range(1, CHUNK_BYTES));
    plan_start();
    cur = 0;
    miss = 0;
    dropped = 1'b0;
    while (cur < n && !dropped) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 4))
          0: plan_beat(REQ_UNUSED, $urandom, 1'($urandom_range(0, 1)));
          1: plan_start();
          2: plan_report($urandom_range(n, SECTION_CHUNKS - 1), 1'($urandom_range(0, 1)));
          3: if (cur > 0) plan_report($urandom_range(0, cur - 1), 1'($urandom_range(0, 1)));
          default: plan_ask();
        endcase
      end
      plan_ask();
      if ($urandom_range(0, 99) < miss_pct) begin
        plan_report(cur, 1'b0);
        miss++;
        dropped = (miss == MAX_TRIES);
      end else begin
        plan_report(cur, 1'b1);
        cur++;
        miss = 0;
      end
    end
    if ($urandom_range(0, 1) == 0) plan_ask();
    plan_report($urandom_range(0, SECTION_CHUNKS - 1), 1'($urandom_range(0, 1)));
  endtask

  // Download every section in order, found reports with an odd miss
  task automatic plan_section_download(input logic [OFF_W-1:0] sz);
    longint unsigned rest;
    int unsigned     chunks;
    plan_size(sz);
    plan_start();
    rest = 64'(sz);
    do begin
      chunks = (rest > SEC_B) ? SECTION_CHUNKS : int'((rest + CHK_B - 1) / CHK_B);
      for (int unsigned i = 0; i < chunks; i++) begin
        if ($urandom_range(0, 7) == 0) plan_ask();
        if ($urandom_range(0, 19) == 0) plan_report(i, 1'b0);
        plan_report(i, 1'b1);
      end
      rest = (rest > SEC_B) ? rest - SEC_B : 0;
    end while (rest != 0);
    plan_ask();
  endtask

  // Driver: hold a beat until accepted, predict on acceptance, feed from the backlog
  always @(posedge clk) begin : drive_requests
    plan_step_t step;
    reply_t     rep;
    logic       v_n;
    logic       we_n;
    if (rst_n) begin
      v_n  = in_valid;
      we_n = 1'b0;
      if (cycle_no[6:0] == 7'd0) send_quiet <= ($urandom_range(0, 3) == 0);
      if (in_valid && !in_stall) begin
        rep = score_request(in_req_type, in_chunk_offset, in_chunk_found);
        predicted_replies.push_back(rep);
        v_n = 1'b0;
      end
      if (!v_n) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
        end else if (backlog.size() == 0) begin
          stim_done <= 1'b1;
        end else begin
          step = backlog[0];
          case (step.kind)
            STEP_BEAT: begin
              if (!tail_calm && !send_quiet && $urandom_range(0, 4) == 0) begin
                send_gap <= $urandom_range(0, 14);
              end else begin
                in_req_type     <= step.req;
                in_chunk_offset <= step.offset;
                in_chunk_found  <= step.found;
                v_n = 1'b1;
                void'(backlog.pop_front());
              end
            end
            STEP_SIZE_WRITE: begin
              // write the size only once every result is back
              if (predicted_replies.size() == 0) begin
                cfg_wdata <= step.size;
                size_reg = step.size;
                we_n = 1'b1;
                void'(backlog.pop_front());
              end
            end
            default: begin
              if (predicted_replies.size() == 0) void'(backlog.pop_front());
            end
          endcase
        end
        if (backlog.size() < CALM_TAIL) tail_calm <= 1'b1;
      end
      in_valid <= v_n;
      cfg_we   <= we_n;
    end
  end

  // Monitor: compare each result beat with the oldest prediction, stall in bursts
  always @(posedge clk) begin : check_replies
    reply_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (predicted_replies.size() == 0) begin
          $error("result beat with no prediction waiting: status %0d", out_status);
          mismatches++;
        end else begin
          want = predicted_replies.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (out_next_offset !== want.next_offset) begin
            $error("next_offset: expected %0h, got %0h", want.next_offset, out_next_offset);
            mismatches++;
          end
          if (out_flush_length !== want.flush_length) begin
            $error("flush_length: expected %0d, got %0d", want.flush_length, out_flush_length);
            mismatches++;
          end
          if (out_section_done !== want.section_done) begin
            $error("section_done: expected %0b, got %0b", want.section_done, out_section_done);
            mismatches++;
          end
          if (out_download_done !== want.download_done) begin
            $error("download_done: expected %0b, got %0b", want.download_done,
                   out_download_done);
            mismatches++;
          end
        end
      end
      if (cycle_no[6:0] == 7'd64) recv_quiet <= ($urandom_range(0, 3) == 0);
      if (tail_calm || recv_quiet) begin
        out_stall <= 1'b0;
      end else if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 14);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin : watch_progress
    cycle_no <= cycle_no + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run_sequence
    int unsigned n;
    // Not started after reset
    plan_ask();
    plan_report(0, 1'b1);
    // Empty file finishes at once
    plan_size('0);
    plan_start();
    plan_ask();
    plan_report(3, 1'b0);
    plan_beat(REQ_UNUSED, '1, 1'b1);
    // One-byte file; two asks exhaust the section, report from another section
    plan_size(32'd1);
    plan_start();
    plan_ask();
    plan_ask();
    plan_beat(cds_pkg::REQ_REPORT, 32'hFFF0_0FFF, 1'b1);
    // Four chunks: start while active, out of range, unasked and repeated reports, cancel
    plan_size(3 * CHUNK_BYTES + 5);
    plan_start();
    plan_start();
    plan_report(7, 1'b1);
    plan_report(2, 1'b1);
    plan_report(2, 1'b1);
    plan_report(2, 1'b0);
    repeat (MAX_TRIES) plan_report(0, 1'b0);
    plan_ask();

    // Full single section, then the largest file up to a cancel, then two sections
    plan_section_download(32'(SEC_B));
    plan_size('1);
    plan_start();
    n = $urandom_range(2, 5);
    for (int unsigned i = 0; i < n; i++) begin
      plan_ask();
      plan_report(i, 1'b1);
    end
    plan_ask();
    repeat (MAX_TRIES) plan_report(n + 1, 1'b0);
    plan_report(0, 1'b1);
    plan_section_download(32'(SEC_B) + $urandom_range(1, 3 * CHUNK_BYTES));

    // Random episodes until the beat budget is spent
    while (beats_planned < BEAT_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // scramble a small download, then sweep every chunk found
          n = $urandom_range(1, 20);
          plan_size(n * CHUNK_BYTES - $urandom_range(0, CHUNK_BYTES - 1));
          plan_start();
          repeat (30) begin
            if ($urandom_range(0, 1) == 0)
              plan_report($urandom_range(0, n + 2), 1'($urandom_range(0, 1)));
            else
              plan_beat(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)));
          end
          for (int unsigned i = 0; i < n; i++) plan_report(i, 1'b1);
        end
        2: begin
          plan_settle();
          plan_small_download(45);
        end
        9: begin
          plan_size('0);
          plan_start();
          plan_ask();
          plan_report($urandom_range(0, SECTION_CHUNKS - 1), 1'($urandom_range(0, 1)));
        end
        default: plan_small_download(12);
      endcase
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (!(stim_done && predicted_replies.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
